// ===== rtl/a1rp_pkg.sv =====
// ----------------------------------------------------------------------------
// a1rp_pkg: shared types and constants of the A1 range reference parser
// Field widths, parse limits, character codes, register indexes and the
// token record handed from the front parser to the back checker.
// ----------------------------------------------------------------------------
package a1rp_pkg;

  localparam int CHAR_W  = 16;
  localparam int SIDX_W  = 16;
  localparam int COL_W   = 14;
  localparam int ROW_W   = 20;
  localparam int SHEET_W = 15;
  localparam int CACC_W  = 29;   // bijective base-26 column, up to six letters
  localparam int RACC_W  = 30;   // decimal row, up to nine digits
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  // accumulator values at or above these take no further letter / digit
  localparam logic [CACC_W-1:0] SIX_LETTER_COLUMN = CACC_W'(12356631);
  localparam logic [RACC_W-1:0] NINE_DIGIT_ROW    = RACC_W'(100000000);
  localparam logic [CACC_W-1:0] COL_RADIX         = CACC_W'(26);
  localparam logic [RACC_W-1:0] ROW_RADIX         = RACC_W'(10);

  localparam logic [CHAR_W-1:0] CH_LOWER_A  = 16'h0061;
  localparam logic [CHAR_W-1:0] CH_LOWER_Z  = 16'h007A;
  localparam logic [CHAR_W-1:0] CH_UPPER_A  = 16'h0041;
  localparam logic [CHAR_W-1:0] CH_UPPER_Z  = 16'h005A;
  localparam logic [CHAR_W-1:0] CH_DIGIT_0  = 16'h0030;
  localparam logic [CHAR_W-1:0] CH_DIGIT_9  = 16'h0039;
  localparam logic [CHAR_W-1:0] CH_COLON    = 16'h003A;
  localparam logic [CHAR_W-1:0] CASE_OFFSET = 16'h0020;

  localparam logic [COL_W-1:0]   MAX_COLUMN_RST = COL_W'(16383);
  localparam logic [ROW_W-1:0]   MAX_ROW_RST    = ROW_W'(1048575);
  localparam logic [SHEET_W-1:0] MAX_SHEET_RST  = SHEET_W'(255);

  localparam int QUEUE_DEPTH_DEF = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_COLUMN = 2'd0,
    REG_MAX_ROW    = 2'd1,
    REG_MAX_SHEET  = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    PH_COL1 = 2'd0,
    PH_ROW1 = 2'd1,
    PH_COL2 = 2'd2,
    PH_ROW2 = 2'd3
  } phase_t;

  typedef struct packed {
    logic [COL_W-1:0]   max_column;
    logic [ROW_W-1:0]   max_row;
    logic [SHEET_W-1:0] max_sheet;
  } limits_t;

  typedef struct packed {
    logic                     perr;
    logic                     two_half;
    logic [CACC_W-1:0]        first_col;
    logic [RACC_W-1:0]        first_row;
    logic [CACC_W-1:0]        col;
    logic [RACC_W-1:0]        row;
    logic signed [SIDX_W-1:0] sheet;
    logic                     track;
  } token_t;

endpackage

// ===== rtl/a1_range_reference_parser.sv =====
// ----------------------------------------------------------------------------
// a1_range_reference_parser: A1 cell range reference parser
// Parses "addr" or "addr:addr" one character per transaction and returns
// the zero-based, ordered and clipped range with sticky overflow flags.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake          carries
//  -------  ---------  -----------------  ------------------------------------
//  in_      input      in_valid/in_stall  one character, last flag, sheet,
//                                         overflow tracking enable
//  out_     output     out_valid/out_stall  one result per token
//  cfg_     input      cfg_valid/cfg_ready  register index and write data
//
//  One character transaction per cycle while in_stall is low. A token's result
//  passes through the queue write, the bound ordering stage and the limit
//  check into the output register before it shows on out_valid.
//  Reset (rst_n low, synchronous) clears parse state, queue, pipeline valids
//  and sticky flags, and loads the limit registers with their defaults.
//  in_stall rises only when the token queue is full, which happens when
//  out_stall holds results back over several tokens; every character is then
//  held, also those of a token that is not yet finished.
//
module a1_range_reference_parser #(
  parameter int QUEUE_DEPTH = a1rp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // character input
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [a1rp_pkg::CHAR_W-1:0]        in_char_code,
  input  logic                               in_last_char,
  input  logic signed [a1rp_pkg::SIDX_W-1:0] in_sheet_index,
  input  logic                               in_track_overflow,
  // result output
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [a1rp_pkg::COL_W-1:0]         out_start_column,
  output logic [a1rp_pkg::ROW_W-1:0]         out_start_row,
  output logic [a1rp_pkg::COL_W-1:0]         out_end_column,
  output logic [a1rp_pkg::ROW_W-1:0]         out_end_row,
  output logic                               out_range_valid,
  output logic                               out_column_overflow_flag,
  output logic                               out_row_overflow_flag,
  output logic                               out_sheet_overflow_flag,
  // register writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [a1rp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [a1rp_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import a1rp_pkg::*;

  limits_t limits_r;
  token_t  push_entry, pop_entry;
  logic    q_push, q_full, q_pop, q_not_empty;

  // limits are to be written only while the block is idle (the block does not enforce it); always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limits_r.max_column <= MAX_COLUMN_RST;
      limits_r.max_row    <= MAX_ROW_RST;
      limits_r.max_sheet  <= MAX_SHEET_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MAX_COLUMN: limits_r.max_column <= cfg_wdata[COL_W-1:0];
        REG_MAX_ROW:    limits_r.max_row    <= cfg_wdata[ROW_W-1:0];
        REG_MAX_SHEET:  limits_r.max_sheet  <= cfg_wdata[SHEET_W-1:0];
        default:        ;  // unused index, write dropped
      endcase
    end
  end

  // front: grammar and accumulators, one character per cycle unless the queue is full
  a1rp_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_char_code      (in_char_code),
    .in_last_char      (in_last_char),
    .in_sheet_index    (in_sheet_index),
    .in_track_overflow (in_track_overflow),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_entry           (push_entry)
  );

  // finished tokens wait here so the parser keeps going under out_stall
  a1rp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wr_entry  (push_entry),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .rd_entry  (pop_entry)
  );

  // back: bound ordering, limit checks, clipping, sticky flags
  a1rp_back u_back (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .limits                   (limits_r),
    .q_not_empty              (q_not_empty),
    .q_entry                  (pop_entry),
    .q_pop                    (q_pop),
    .out_valid                (out_valid),
    .out_stall                (out_stall),
    .out_start_column         (out_start_column),
    .out_start_row            (out_start_row),
    .out_end_column           (out_end_column),
    .out_end_row              (out_end_row),
    .out_range_valid          (out_range_valid),
    .out_column_overflow_flag (out_column_overflow_flag),
    .out_row_overflow_flag    (out_row_overflow_flag),
    .out_sheet_overflow_flag  (out_sheet_overflow_flag)
  );

  // a valid range comes out ordered
  a_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_range_valid) |->
      (out_start_column <= out_end_column) && (out_start_row <= out_end_row))
    else $error("valid range with reversed bounds");

  // an invalid result carries no coordinates
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_range_valid) |->
      (out_start_column == '0) && (out_start_row == '0) &&
      (out_end_column == '0) && (out_end_row == '0))
    else $error("invalid result with nonzero coordinates");

  // clipped end stays inside the configured limits
  a_clipped: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_range_valid) |->
      (out_end_column <= limits_r.max_column) && (out_end_row <= limits_r.max_row))
    else $error("end bound beyond limit");

  // no push into a full queue
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !q_push)
    else $error("token queue overrun");

endmodule

// ===== rtl/a1rp_front.sv =====
// ----------------------------------------------------------------------------
// a1rp_front: character parser
// Takes one character per cycle while the queue is not full, runs the address
// grammar and pushes one token record into the queue on the last character.
// ----------------------------------------------------------------------------
module a1rp_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [a1rp_pkg::CHAR_W-1:0]     in_char_code,
  input  logic                            in_last_char,
  input  logic signed [a1rp_pkg::SIDX_W-1:0] in_sheet_index,
  input  logic                            in_track_overflow,
  input  logic                            q_full,
  output logic                            q_push,
  output a1rp_pkg::token_t                q_entry
);
  import a1rp_pkg::*;

  phase_t              phase_r, phase_nxt, ph_eff;
  logic                perr_r, perr_nxt;
  logic [CACC_W-1:0]   col_r, col_nxt, fcol_r, fcol_nxt;
  logic [RACC_W-1:0]   row_r, row_nxt, frow_r, frow_nxt;
  logic [CHAR_W-1:0]   cu;
  logic                is_letter, is_digit, is_colon, take_row, accept;

  assign cu        = (in_char_code >= CH_LOWER_A && in_char_code <= CH_LOWER_Z) ?
                     in_char_code - CASE_OFFSET : in_char_code;
  assign is_letter = (cu >= CH_UPPER_A) && (cu <= CH_UPPER_Z);
  assign is_digit  = (in_char_code >= CH_DIGIT_0) && (in_char_code <= CH_DIGIT_9);
  assign is_colon  = (in_char_code == CH_COLON);

  // next parse state for the current character
  always_comb begin
    phase_nxt = phase_r;
    perr_nxt  = perr_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    fcol_nxt  = fcol_r;
    frow_nxt  = frow_r;
    take_row  = 1'b0;
    ph_eff    = phase_r;
    if (!perr_r) begin
      if (phase_r == PH_COL1 || phase_r == PH_COL2) begin
        if (is_letter) begin
          if (col_r >= SIX_LETTER_COLUMN) begin
            perr_nxt = 1'b1;
          end else begin
            // 'A'..'Z' low five bits are 1..26
            col_nxt = col_r * COL_RADIX + CACC_W'(cu[4:0]);
          end
        end else if (col_r == '0) begin
          perr_nxt = 1'b1;
        end else begin
          take_row = 1'b1;
          ph_eff   = (phase_r == PH_COL1) ? PH_ROW1 : PH_ROW2;
        end
      end else begin
        take_row = 1'b1;
      end
      if (take_row) begin
        phase_nxt = ph_eff;
        if (is_digit) begin
          if (row_r >= NINE_DIGIT_ROW) begin
            perr_nxt = 1'b1;
          end else begin
            row_nxt = row_r * ROW_RADIX + RACC_W'(in_char_code[3:0]);
          end
        end else if (is_colon && ph_eff == PH_ROW1) begin
          fcol_nxt  = col_r;
          frow_nxt  = row_r;
          col_nxt   = '0;
          row_nxt   = '0;
          phase_nxt = PH_COL2;
        end else begin
          perr_nxt = 1'b1;
        end
      end
    end
  end

  // queue side
  always_comb begin
    accept            = in_valid && !q_full;
    in_stall          = q_full;
    q_push            = accept && in_last_char;
    q_entry.perr      = perr_nxt;
    q_entry.two_half  = phase_nxt[1];
    q_entry.first_col = fcol_nxt;
    q_entry.first_row = frow_nxt;
    q_entry.col       = col_nxt;
    q_entry.row       = row_nxt;
    q_entry.sheet     = in_sheet_index;
    q_entry.track     = in_track_overflow;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (accept && in_last_char)) begin
      phase_r <= PH_COL1;
      perr_r  <= 1'b0;
      col_r   <= '0;
      row_r   <= '0;
      fcol_r  <= '0;
      frow_r  <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      perr_r  <= perr_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      fcol_r  <= fcol_nxt;
      frow_r  <= frow_nxt;
    end
  end

endmodule

// ===== rtl/a1rp_queue.sv =====
// ----------------------------------------------------------------------------
// a1rp_queue: token queue
// Small FIFO of parsed token records between the parser and the checker.
// ----------------------------------------------------------------------------
module a1rp_queue #(
  parameter int DEPTH = a1rp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  a1rp_pkg::token_t wr_entry,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output a1rp_pkg::token_t rd_entry
);
  import a1rp_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  token_t             mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign rd_entry  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
      count_r <= count_nxt;
    end
  end

endmodule

// ===== rtl/a1rp_back.sv =====
// ----------------------------------------------------------------------------
// a1rp_back: range checker
// Two stages: order the bounds, then check limits, clip, update the sticky
// overflow flags and hold the result for the output channel.
// ----------------------------------------------------------------------------
module a1rp_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  a1rp_pkg::limits_t            limits,
  input  logic                         q_not_empty,
  input  a1rp_pkg::token_t             q_entry,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [a1rp_pkg::COL_W-1:0]   out_start_column,
  output logic [a1rp_pkg::ROW_W-1:0]   out_start_row,
  output logic [a1rp_pkg::COL_W-1:0]   out_end_column,
  output logic [a1rp_pkg::ROW_W-1:0]   out_end_row,
  output logic                         out_range_valid,
  output logic                         out_column_overflow_flag,
  output logic                         out_row_overflow_flag,
  output logic                         out_sheet_overflow_flag
);
  import a1rp_pkg::*;

  // stage A: ordered bounds
  logic                     a_valid_r, a_ready, a_ok_r, a_ok_nxt, a_track_r;
  logic [CACC_W-1:0]        a_sc_r, a_ec_r, a_sc_nxt, a_ec_nxt, c_lo, c_hi;
  logic [RACC_W-1:0]        a_sr_r, a_er_r, a_sr_nxt, a_er_nxt, r_lo, r_hi;
  logic signed [SIDX_W-1:0] a_sheet_r;

  // stage B: limits and result
  logic b_load;
  logic ec_over, er_over, sc_over, sr_over, sheet_neg, sheet_over, sheet_bad, ok;
  logic set_col, set_row, set_sheet;
  logic col_flag_r, row_flag_r, sheet_flag_r;
  logic out_valid_r;

  always_comb begin
    c_lo = q_entry.two_half ? q_entry.first_col : q_entry.col;
    r_lo = q_entry.two_half ? q_entry.first_row : q_entry.row;
    c_hi = q_entry.col;
    r_hi = q_entry.row;
    a_ok_nxt = !q_entry.perr && (c_hi != '0) && (r_hi != '0) &&
               (c_lo != '0) && (r_lo != '0);
    // compare before the one-based to zero-based step, same order
    if (c_lo > c_hi) begin
      a_sc_nxt = c_hi - 1'b1;
      a_ec_nxt = c_lo - 1'b1;
    end else begin
      a_sc_nxt = c_lo - 1'b1;
      a_ec_nxt = c_hi - 1'b1;
    end
    if (r_lo > r_hi) begin
      a_sr_nxt = r_hi - 1'b1;
      a_er_nxt = r_lo - 1'b1;
    end else begin
      a_sr_nxt = r_lo - 1'b1;
      a_er_nxt = r_hi - 1'b1;
    end
  end

  assign b_load  = a_valid_r && (!out_valid_r || !out_stall);
  assign a_ready = !a_valid_r || b_load;
  assign q_pop   = q_not_empty && a_ready;

  // checks run in order: end bounds, sheet, start column, start row
  always_comb begin
    ec_over    = a_ec_r > CACC_W'(limits.max_column);
    er_over    = a_er_r > RACC_W'(limits.max_row);
    sc_over    = a_sc_r > CACC_W'(limits.max_column);
    sr_over    = a_sr_r > RACC_W'(limits.max_row);
    sheet_neg  = a_sheet_r[SIDX_W-1];
    sheet_over = !sheet_neg && (a_sheet_r[SHEET_W-1:0] > limits.max_sheet);
    sheet_bad  = sheet_neg || sheet_over;
    ok         = a_ok_r && !sheet_bad && !sc_over && !sr_over;
    set_col    = a_track_r && a_ok_r && (ec_over || (!sheet_bad && sc_over));
    set_row    = a_track_r && a_ok_r &&
                 (er_over || (!sheet_bad && !sc_over && sr_over));
    set_sheet  = a_track_r && a_ok_r && sheet_over;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r    <= 1'b0;
      out_valid_r  <= 1'b0;
      col_flag_r   <= 1'b0;
      row_flag_r   <= 1'b0;
      sheet_flag_r <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_r <= q_not_empty;
      end
      if (b_load) begin
        out_valid_r  <= 1'b1;
        col_flag_r   <= col_flag_r | set_col;
        row_flag_r   <= row_flag_r | set_row;
        sheet_flag_r <= sheet_flag_r | set_sheet;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      a_ok_r    <= a_ok_nxt;
      a_sc_r    <= a_sc_nxt;
      a_ec_r    <= a_ec_nxt;
      a_sr_r    <= a_sr_nxt;
      a_er_r    <= a_er_nxt;
      a_sheet_r <= q_entry.sheet;
      a_track_r <= q_entry.track;
    end
    if (b_load) begin
      out_range_valid          <= ok;
      out_start_column         <= ok ? a_sc_r[COL_W-1:0] : '0;
      out_start_row            <= ok ? a_sr_r[ROW_W-1:0] : '0;
      out_end_column           <= !ok ? '0 : (ec_over ? limits.max_column : a_ec_r[COL_W-1:0]);
      out_end_row              <= !ok ? '0 : (er_over ? limits.max_row : a_er_r[ROW_W-1:0]);
      out_column_overflow_flag <= col_flag_r | set_col;
      out_row_overflow_flag    <= row_flag_r | set_row;
      out_sheet_overflow_flag  <= sheet_flag_r | set_sheet;
    end
  end

  assign out_valid = out_valid_r;

endmodule
